/* rtl/core/vbf_pkg.sv */
package vbf_pkg;

    localparam int ROWS          = 4096;
    localparam int ROW_W         = 12;
    localparam int TABLE_COUNT   = 5;
    localparam int TABLE_W       = 3;
    localparam int WORD_BITS     = 64;
    localparam int BIT_POS_W     = 6;
    localparam int MAX_COLS_DEF  = 256;
    localparam int BANK_DEPTH_DEF = ROWS * ((MAX_COLS_DEF + WORD_BITS - 1) / WORD_BITS);
    localparam int BANK_ADDR_W_DEF = $clog2(BANK_DEPTH_DEF);

    localparam int COL_COUNT_W = 9;
    localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = 9'd256;
    localparam logic GATE_ENABLE_RST = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GATE_ENABLE = 1'd1;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    localparam int HASH_W     = 32;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CHUNKS = HASH_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CHUNKS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_RSP
    } t_state;

    typedef struct packed {
        logic                 rd;
        logic                 set;
        logic                 clr;
        logic [BIT_POS_W-1:0] bit_pos;
    } t_bank_op;

endpackage

/* rtl/core/vbf_bank.sv */
module vbf_bank
    import vbf_pkg::*;
#(
    parameter int DEPTH  = BANK_DEPTH_DEF,
    parameter int ADDR_W = BANK_ADDR_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_bank_op             i_op,
    input  logic [ADDR_W-1:0]    i_addr,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_set_pend;
    logic [ADDR_W-1:0]    r_addr;
    logic [BIT_POS_W-1:0] r_bit_pos;
    logic [WORD_BITS-1:0] w_mask;

    assign w_mask  = {1'b1, {(WORD_BITS-1){1'b0}}} >> r_bit_pos;
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_pend <= 1'b0;
        end else begin
            r_set_pend <= i_op.set;
        end
    end

    // clear a word, or read it; for a set, write it back with the column bit set in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_op.clr) begin
            r_mem[i_addr] <= '0;
        end else if (r_set_pend) begin
            r_mem[r_addr] <= r_rdata | w_mask;
        end
        if (i_op.rd || i_op.set) begin
            r_rdata <= r_mem[i_addr];
        end
        r_addr    <= i_addr;
        r_bit_pos <= i_op.bit_pos;
    end

endmodule

/* rtl/core/vector_bloom_filter_update.sv */
// Vector Bloom filter recorder with five bit tables of 4096 rows, each row
// ceil(MAX_COLS/64) words of 64 bits, one single-port synchronous memory per
// table. After reset the block clears all 4096*ceil(MAX_COLS/64) words (16384
// at the default) with o_in_stall high. A record is taken in ST_IDLE, its
// column found by the remainder unit in ST_DIV (eight bits of element_hash per
// cycle), then all five memories are read and written back in parallel. A
// record dropped by the gate leaves the block in ST_IDLE. A read loads the
// output register in ST_RSP, and waits there while i_out_stall holds an
// earlier word. o_in_stall stays high until a transfer is done. Configuration
// is written through i_cfg_we, i_cfg_index and i_cfg_data.
module vector_bloom_filter_update
    import vbf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [COL_COUNT_W-1:0] i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_req_type,
    input  logic [HASH_W-1:0]      i_src_ip,
    input  logic [HASH_W-1:0]      i_flow_hash,
    input  logic [HASH_W-1:0]      i_element_hash,
    input  logic                   i_gate_full,
    input  logic [TABLE_W-1:0]     i_read_table,
    input  logic [ROW_W-1:0]       i_read_row,
    input  logic [1:0]             i_read_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [WORD_BITS-1:0]   o_read_data
);

    localparam int WPR    = (MAX_COLS + WORD_BITS - 1) / WORD_BITS;
    localparam int WW     = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int DEPTH  = ROWS * WPR;
    localparam int AW     = $clog2(DEPTH);
    localparam int MW     = $clog2(MAX_COLS + 1);

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_clr_addr;
    logic [COL_COUNT_W-1:0] r_col_count;
    logic                   r_gate_en;
    logic [ROW_W-1:0]       r_row [TABLE_COUNT];
    logic [HASH_W-1:0]      r_eh;
    logic [MW-1:0]          r_mod;
    logic [MW-1:0]          r_rem;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [TABLE_W-1:0]     r_rd_table;
    logic                   r_rd_zero;
    logic                   r_out_valid;
    logic [WORD_BITS-1:0]   r_read_data;

    logic                   w_accept;
    logic                   w_drop;
    logic                   w_load;
    logic [MW-1:0]          w_mod;
    logic [MW-1:0]          w_rem_next;
    logic [WW-1:0]          w_col_word;
    logic [WW-1:0]          w_rd_word;
    logic [ROW_W-1:0]       w_row [TABLE_COUNT];
    logic [AW-1:0]          w_addr [TABLE_COUNT];
    logic [WORD_BITS-1:0]   w_rdata [TABLE_COUNT];
    t_bank_op               w_op;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_drop      = r_gate_en && !i_gate_full;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

    // rows from the source octets and the flow hash
    always_comb begin
        for (int k = 0; k < TABLE_COUNT - 1; k++) begin
            w_row[k] = {i_src_ip[31 - 8*k -: 8], i_src_ip[31 - 8*((k + 1) % 4) -: 4]};
        end
        w_row[TABLE_COUNT-1] = i_flow_hash[ROW_W-1:0];
    end

    always_comb begin
        if (r_col_count == '0 || 32'(r_col_count) > MAX_COLS) begin
            w_mod = MW'(MAX_COLS);
        end else begin
            w_mod = MW'(r_col_count);
        end
    end

    // restoring remainder, eight dividend bits per cycle
    always_comb begin
        logic [MW:0] t;
        w_rem_next = r_rem;
        for (int s = 0; s < DIV_STEPS; s++) begin
            t = {w_rem_next, r_eh[HASH_W-1-s]};
            if (t >= {1'b0, r_mod}) begin
                t = t - {1'b0, r_mod};
            end
            w_rem_next = t[MW-1:0];
        end
    end

    assign w_col_word = WW'(32'(r_rem) >> BIT_POS_W);
    assign w_rd_word  = WW'(i_read_word);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_READ) begin
                        n_state = ST_RSP;
                    end else if (!w_drop) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(DIV_CHUNKS - 1)) begin
                    n_state = ST_RMW_RD;
                end
            end
            ST_RMW_RD: n_state = ST_RMW_WR;
            ST_RMW_WR: n_state = ST_IDLE;
            ST_RSP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_op    = '0;
        w_load  = 1'b0;
        for (int k = 0; k < TABLE_COUNT; k++) begin
            w_addr[k] = r_clr_addr;
        end
        case (r_state)
            ST_CLEAR: begin
                w_op.clr = 1'b1;
            end
            ST_IDLE: begin
                w_op.rd = w_accept && (i_req_type == REQ_READ);
                for (int k = 0; k < TABLE_COUNT; k++) begin
                    w_addr[k] = AW'(32'(i_read_row) * WPR + 32'(w_rd_word));
                end
            end
            ST_RMW_RD: begin
                w_op.set     = 1'b1;
                w_op.bit_pos = r_rem[BIT_POS_W-1:0];
                for (int k = 0; k < TABLE_COUNT; k++) begin
                    w_addr[k] = AW'(32'(r_row[k]) * WPR + 32'(w_col_word));
                end
            end
            ST_RSP: begin
                w_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                w_op = '0;
            end
        endcase
    end

    for (genvar g = 0; g < TABLE_COUNT; g++) begin : g_bank
        vbf_bank #(
            .DEPTH  (DEPTH),
            .ADDR_W (AW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_addr  (w_addr[g]),
            .o_rdata (w_rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_col_count <= COL_COUNT_RST;
            r_gate_en   <= GATE_ENABLE_RST;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_load || (r_out_valid && i_out_stall);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COL_COUNT:   r_col_count <= i_cfg_data;
                    REG_GATE_ENABLE: r_gate_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == ST_DIV) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end else begin
                r_div_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < TABLE_COUNT; k++) begin
                r_row[k] <= w_row[k];
            end
            r_eh       <= i_element_hash;
            r_mod      <= w_mod;
            r_rem      <= '0;
            r_rd_table <= i_read_table;
            r_rd_zero  <= (32'(i_read_table) >= TABLE_COUNT) || (32'(i_read_word) >= WPR);
        end else if (r_state == ST_DIV) begin
            r_eh  <= r_eh << DIV_STEPS;
            r_rem <= w_rem_next;
        end
        if (w_load) begin
            r_read_data <= r_rd_zero ? '0 : w_rdata[r_rd_table];
        end
    end

endmodule

/* test/vector_bloom_filter_update_checker.sv */
`timescale 1ns / 100ps

module vector_bloom_filter_update_checker
    import vbf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [COL_COUNT_W-1:0] i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_req_type,
    input  logic [HASH_W-1:0]      i_src_ip,
    input  logic [HASH_W-1:0]      i_flow_hash,
    input  logic [HASH_W-1:0]      i_element_hash,
    input  logic                   i_gate_full,
    input  logic [TABLE_W-1:0]     i_read_table,
    input  logic [ROW_W-1:0]       i_read_row,
    input  logic [1:0]             i_read_word,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [WORD_BITS-1:0]   i_read_data,
    output int                     o_fail_count,
    output int                     o_words_pending,
    output int                     o_words_checked,
    output int                     o_records_applied
);

    localparam int WORDS_PER_ROW = (MAX_COLS_DEF + WORD_BITS - 1) / WORD_BITS;

    logic [WORD_BITS-1:0]   row_words [TABLE_COUNT*ROWS*WORDS_PER_ROW];
    logic [WORD_BITS-1:0]   expected_words [$];
    logic [COL_COUNT_W-1:0] col_count;
    logic                   gate_enable;
    int                     fails;
    int                     checked;
    int                     applied;

    function automatic int word_index(int unsigned tbl, int unsigned row, int unsigned w);
        return (tbl * ROWS + row) * WORDS_PER_ROW + w;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_BITS-1:0] got,
                                   logic [WORD_BITS-1:0] want);
        $display("%0t: mismatch on %s: got %h want %h", $time, what, got, want);
        fails++;
    endtask

    task automatic record_packet();
        int unsigned      modulus;
        int unsigned      col;
        logic [ROW_W-1:0] rows [TABLE_COUNT];
        if (gate_enable && !i_gate_full) begin
            return;
        end
        modulus = (col_count == 0 || col_count > MAX_COLS_DEF) ? MAX_COLS_DEF : col_count;
        col = i_element_hash % modulus;
        for (int k = 0; k < 4; k++) begin
            rows[k] = {i_src_ip[31-8*k -: 8], i_src_ip[31-8*((k+1)%4) -: 4]};
        end
        rows[4] = i_flow_hash[ROW_W-1:0];
        for (int k = 0; k < TABLE_COUNT; k++) begin
            row_words[word_index(k, 32'(rows[k]), col / WORD_BITS)]
                [WORD_BITS-1 - col % WORD_BITS] = 1'b1;
        end
        applied++;
    endtask

    task automatic read_word();
        logic [WORD_BITS-1:0] data;
        data = '0;
        if (i_read_table < TABLE_COUNT && i_read_word < WORDS_PER_ROW) begin
            data = row_words[word_index(32'(i_read_table), 32'(i_read_row),
                                        32'(i_read_word))];
        end
        expected_words.insert(expected_words.size(), data);
    endtask

    always @(posedge i_clk) begin
        logic [WORD_BITS-1:0] want;
        if (!i_rst_n) begin
            foreach (row_words[n]) row_words[n] = '0;
            expected_words.delete();
            col_count = COL_COUNT_RST;
            gate_enable = GATE_ENABLE_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COL_COUNT: col_count = i_cfg_data;
                    REG_GATE_ENABLE: gate_enable = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("read_data with no read outstanding", i_read_data, '0);
                end else begin
                    want = expected_words.pop_front();
                    checked++;
                    if (i_read_data !== want) begin
                        report_mismatch("read_data", i_read_data, want);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_req_type == REQ_READ) begin
                    read_word();
                end else begin
                    record_packet();
                end
            end
        end
        o_fail_count <= fails;
        o_words_pending <= expected_words.size();
        o_words_checked <= checked;
        o_records_applied <= applied;
    end

endmodule

/* test/vector_bloom_filter_update_tb.sv */
`timescale 1ns / 100ps

module vector_bloom_filter_update_tb;
    import vbf_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [COL_COUNT_W-1:0] i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_req_type = 1'b0;
    logic [HASH_W-1:0]      i_src_ip = '0;
    logic [HASH_W-1:0]      i_flow_hash = '0;
    logic [HASH_W-1:0]      i_element_hash = '0;
    logic                   i_gate_full = 1'b0;
    logic [TABLE_W-1:0]     i_read_table = '0;
    logic [ROW_W-1:0]       i_read_row = '0;
    logic [1:0]             i_read_word = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [WORD_BITS-1:0]   o_read_data;

    int fail_count;
    int words_pending;
    int words_checked;
    int records_applied;

    int sent = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int recv_stall_pct = 0;
    int send_idle_pct = 0;

    logic [31:0] ip_pool [8];
    logic [31:0] fh_pool [8];

    vector_bloom_filter_update dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_src_ip       (i_src_ip),
        .i_flow_hash    (i_flow_hash),
        .i_element_hash (i_element_hash),
        .i_gate_full    (i_gate_full),
        .i_read_table   (i_read_table),
        .i_read_row     (i_read_row),
        .i_read_word    (i_read_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data)
    );

    vector_bloom_filter_update_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_src_ip          (i_src_ip),
        .i_flow_hash       (i_flow_hash),
        .i_element_hash    (i_element_hash),
        .i_gate_full       (i_gate_full),
        .i_read_table      (i_read_table),
        .i_read_row        (i_read_row),
        .i_read_word       (i_read_word),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_read_data       (o_read_data),
        .o_fail_count      (fail_count),
        .o_words_pending   (words_pending),
        .o_words_checked   (words_checked),
        .o_records_applied (records_applied)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("timeout at %0t with transfers still outstanding", $time);
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            i_out_stall <= 1'b1;
            hold_left <= 299;
            hold_seen <= hold_req;
        end else begin
            i_out_stall <= $urandom_range(0, 99) < recv_stall_pct;
        end
    end

    task automatic send(input logic rt, input logic [31:0] ip, input logic [31:0] fh,
                        input logic [31:0] eh, input logic gate,
                        input logic [TABLE_W-1:0] tbl, input logic [ROW_W-1:0] row,
                        input logic [1:0] w);
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_src_ip <= ip;
        i_flow_hash <= fh;
        i_element_hash <= eh;
        i_gate_full <= gate;
        i_read_table <= tbl;
        i_read_row <= row;
        i_read_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic send_random();
        logic [31:0]        ip;
        logic [31:0]        fh;
        logic [TABLE_W-1:0] tbl;
        logic [ROW_W-1:0]   row;
        int                 j;
        int                 k;
        j = int'($urandom_range(0, 7));
        if ($urandom_range(0, 24) == 0) begin
            ip_pool[j] = $urandom;
            fh_pool[j] = $urandom;
        end
        ip = ($urandom_range(0, 9) < 7) ? ip_pool[j] : $urandom;
        fh = ($urandom_range(0, 9) < 7) ? fh_pool[j] : $urandom;
        if ($urandom_range(0, 99) < 55) begin
            send(REQ_RECORD, ip, fh, $urandom, $urandom_range(0, 3) != 0,
                 TABLE_W'($urandom), ROW_W'($urandom), 2'($urandom));
        end else begin
            if ($urandom_range(0, 9) != 0) begin
                tbl = TABLE_W'($urandom_range(0, TABLE_COUNT - 1));
            end else begin
                tbl = TABLE_W'($urandom_range(TABLE_COUNT, 7));
            end
            k = int'(tbl);
            // aim most reads at rows the pool addresses have touched
            if ($urandom_range(0, 4) == 0) begin
                row = ROW_W'($urandom);
            end else if (k < 4) begin
                row = {ip_pool[j][31-8*k -: 8], ip_pool[j][31-8*((k+1)%4) -: 4]};
            end else begin
                row = fh_pool[j][ROW_W-1:0];
            end
            send(REQ_READ, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                 tbl, row, 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [COL_COUNT_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int col_plan [6];
        int gate_plan [6];
        int idle_mix [4];
        int stall_mix [4];
        col_plan = '{256, 1, 511, 0, 100, 0};
        gate_plan = '{1, 0, 1, 0, 1, 0};
        idle_mix = '{0, 56, 0, 37};
        stall_mix = '{0, 0, 56, 37};
        col_plan[5] = int'($urandom_range(2, 255));
        for (int n = 0; n < 8; n++) begin
            ip_pool[n] = $urandom;
            fh_pool[n] = $urandom;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(REQ_READ, $urandom, $urandom, $urandom, 1'b1, '0, '0, '0);
        send(REQ_RECORD, 32'h0, 32'h0, 32'h0, 1'b1,
             TABLE_W'($urandom), ROW_W'($urandom), 2'($urandom));
        send(REQ_RECORD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
             TABLE_W'($urandom), ROW_W'($urandom), 2'($urandom));
        send(REQ_RECORD, 32'h0, 32'h0, 32'd321, 1'b1,
             TABLE_W'($urandom), ROW_W'($urandom), 2'($urandom));
        // gate closed: dropped
        send(REQ_RECORD, 32'h1234_5678, 32'h0000_0abc, 32'd7, 1'b0,
             TABLE_W'($urandom), ROW_W'($urandom), 2'($urandom));
        for (int t = 0; t < TABLE_COUNT; t++) begin
            send(REQ_READ, $urandom, $urandom, $urandom, 1'b0, TABLE_W'(t), '0, '0);
        end
        for (int t = 0; t < TABLE_COUNT; t++) begin
            send(REQ_READ, $urandom, $urandom, $urandom, 1'b1, TABLE_W'(t), 12'hfff, 2'd3);
        end
        send(REQ_READ, $urandom, $urandom, $urandom, 1'b0, '0, '0, 2'd1);
        send(REQ_READ, $urandom, $urandom, $urandom, 1'b1, '0, 12'h123, '0);
        send(REQ_READ, $urandom, $urandom, $urandom, 1'b0, 3'd4, 12'habc, '0);
        send(REQ_READ, $urandom, $urandom, $urandom, 1'b1, 3'd5, '0, '0);
        send(REQ_READ, $urandom, $urandom, $urandom, 1'b0, 3'd7, 12'hfff, 2'd3);
        send(REQ_READ, $urandom, $urandom, $urandom, 1'b1, '0, '0, 2'd2);

        for (int p = 0; p < 6; p++) begin
            settle();
            write_reg(REG_COL_COUNT, COL_COUNT_W'(col_plan[p]));
            write_reg(REG_GATE_ENABLE, COL_COUNT_W'(gate_plan[p]));
            send_idle_pct = idle_mix[p % 4];
            recv_stall_pct <= stall_mix[p % 4];
            if (p == 0) begin
                hold_req <= hold_req + 1;
            end
            repeat (72) begin
                if ($urandom_range(0, 99) < send_idle_pct) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
                send_random();
            end
        end
        settle();

        $display("covered %0d transfers in: %0d read words checked, %0d records stored",
                 sent, words_checked, records_applied);
        $display("column counts 0, 1, 100, 256, 511 and random, gate on and off, ",
                 "four idle/stall mixes and one 300-cycle output hold");
        if (fail_count == 0 && words_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
